// ===== sv/fir2_pkg.sv =====
// ----------------------------------------------------------------------------
// fir2_pkg: shared types and constants of the two-channel FIR filter
// Field widths, request codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package fir2_pkg;

  // Sample and coefficient words are Q1.15.
  localparam int DATA_W = 16;
  // Width of the coefficient slot field of a request.
  localparam int CIDX_W = 8;
  // Fraction bits dropped when the Q2.30 sum is rounded back to Q1.15.
  localparam int FRAC_W = 15;

  typedef enum logic {
    ACT_FILTER = 1'b0,
    ACT_COEF   = 1'b1
  } action_e;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RUN   = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_ROUND = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

endpackage

`default_nettype wire

// ===== sv/two_channel_fir_filter_top.sv =====
// ----------------------------------------------------------------------------
// two_channel_fir_filter_top: direct-form FIR filter for audio channels
// One shared 16x16 multiply-accumulate walks the taps of a shared coefficient
// store against a per-channel circular delay line held in on-chip memory.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+---------------------------------
//  in      | input     | in_valid_i / in_ready_o | action, channel, sample,
//          |           |                         | coef_index, coef_value
//  out     | output    | out_valid_o/out_ready_i | out_sample, out_channel
//
// A coefficient write request writes its value straight into the store. A filter
// request runs the single multiply-accumulate unit over the taps at one tap per
// cycle, then drains the memory-read and multiplier stages, then rounds the sum,
// writes the sample back and saturates the result into the output register.
// After reset a clearing pass zeroes both memories; in_ready_o stays low during it.
// A finished sample sits in the output register, so a new request is taken
// while the previous result is still waiting; only the next result waits.
`default_nettype none

module two_channel_fir_filter_top #(
  parameter int TAPS     = 256,
  parameter int CHANNELS = 2
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 action_i,
  input  wire logic                                 channel_i,
  input  wire logic signed [fir2_pkg::DATA_W-1:0]   sample_i,
  input  wire logic        [fir2_pkg::CIDX_W-1:0]   coef_index_i,
  input  wire logic signed [fir2_pkg::DATA_W-1:0]   coef_value_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [fir2_pkg::DATA_W-1:0]        out_sample_o,
  output logic                                      out_channel_o
);
  import fir2_pkg::*;

  // Tap address width; the coefficient store and each delay line live in a
  // power-of-two slot of this size.
  localparam int KW       = $clog2(TAPS);
  localparam int LINE_LEN = TAPS - 1;
  localparam int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DL_DEPTH = CHANNELS * (2 ** KW);
  localparam int DA_W     = $clog2(DL_DEPTH);
  // The exact sum of TAPS Q2.30 products fits in this many bits.
  localparam int ACC_W    = 2 * DATA_W + KW;
  localparam int RW       = ACC_W - FRAC_W;
  localparam int PROD_W   = 2 * DATA_W;

  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1 << (FRAC_W - 1));
  localparam logic signed [RW-1:0]    SAT_HI   = RW'((1 << (DATA_W - 1)) - 1);
  localparam logic signed [RW-1:0]    SAT_LO   = RW'(-(1 << (DATA_W - 1)));

  // --------------------------------------------------------------------------
  // Sequencer and request registers
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [DA_W-1:0]              clr_cnt_q;
  logic [KW-1:0]                n_q;        // tap being fetched
  logic [KW-1:0]                k_q;        // delay line slot being fetched
  logic [KW-1:0]                pos_q;      // slot the new sample overwrites
  logic [CW-1:0]                ch_q;
  logic signed [DATA_W-1:0]     x_q;
  logic [KW-1:0]                wp_q [CHANNELS];

  // MAC pipeline: memory read stage, product stage, accumulator.
  logic                         rd_vld_q;
  logic                         rd_tap0_q;
  logic signed [DATA_W-1:0]     coef_rd_q;
  logic signed [DATA_W-1:0]     dl_rd_q;
  logic                         prod_vld_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [ACC_W-1:0]      acc_q;
  logic signed [ACC_W-1:0]      rnd_sum;
  logic signed [RW-1:0]         rnd_q;

  logic                         in_acc;
  logic                         ch_ok;
  logic                         last_tap;
  logic                         out_free;
  logic signed [DATA_W-1:0]     mul_b;

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0]     coef_mem [2 ** KW];
  logic signed [DATA_W-1:0]     dl_mem   [DL_DEPTH];

  logic                         cf_we;
  logic [KW-1:0]                cf_wa;
  logic signed [DATA_W-1:0]     cf_wd;
  logic                         dl_we;
  logic [DA_W-1:0]              dl_wa;
  logic signed [DATA_W-1:0]     dl_wd;
  logic [DA_W-1:0]              dl_ra;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign ch_ok      = (32'(channel_i) < CHANNELS);
  assign last_tap   = (n_q == KW'(TAPS - 1));
  assign out_free   = !out_valid_o || out_ready_i;

  // Read address of the current delay line; channel selects the slot.
  assign dl_ra = (DA_W'(ch_q) << KW) + DA_W'(k_q);

  always_comb begin
    cf_we = 1'b0;
    cf_wa = clr_cnt_q[KW-1:0];
    cf_wd = '0;
    dl_we = 1'b0;
    dl_wa = clr_cnt_q;
    dl_wd = '0;
    if (state_q == ST_CLEAR) begin
      cf_we = (32'(clr_cnt_q) < TAPS);
      dl_we = 1'b1;
    end else if (in_acc && (action_i == ACT_COEF)) begin
      // Slots at or beyond TAPS do not exist and are dropped.
      cf_we = (32'(coef_index_i) < TAPS);
      cf_wa = KW'(coef_index_i);
      cf_wd = coef_value_i;
    end else if (state_q == ST_ROUND) begin
      dl_we = 1'b1;
      dl_wa = (DA_W'(ch_q) << KW) + DA_W'(pos_q);
      dl_wd = x_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cf_we) begin
      coef_mem[cf_wa] <= cf_wd;
    end
    coef_rd_q <= coef_mem[n_q];
  end

  always_ff @(posedge clk_i) begin
    if (dl_we) begin
      dl_mem[dl_wa] <= dl_wd;
    end
    dl_rd_q <= dl_mem[dl_ra];
  end

  // --------------------------------------------------------------------------
  // State sequencing
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == DA_W'(DL_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc && (action_i == ACT_FILTER) && ch_ok) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (last_tap) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !prod_vld_q) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + DA_W'(1);
      end
    end
  end

  // Write positions are per-channel control state and reset to slot zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wp_q[c] <= '0;
      end
    end else if (state_q == ST_ROUND) begin
      wp_q[ch_q] <= (pos_q == KW'(LINE_LEN - 1)) ? '0 : pos_q + KW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Request capture and tap walk
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q  <= CW'(channel_i);
      x_q   <= sample_i;
      n_q   <= '0;
      k_q   <= wp_q[CW'(channel_i)];
      pos_q <= wp_q[CW'(channel_i)];
    end else if (state_q == ST_RUN) begin
      n_q <= n_q + KW'(1);
      // Tap zero uses the new sample, so the line walk starts at tap one.
      if (n_q != '0) begin
        k_q <= (k_q == KW'(LINE_LEN - 1)) ? '0 : k_q + KW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Multiply-accumulate pipeline
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= (state_q == ST_RUN);
      prod_vld_q <= rd_vld_q;
    end
  end

  assign mul_b = rd_tap0_q ? x_q : dl_rd_q;

  always_ff @(posedge clk_i) begin
    rd_tap0_q <= (n_q == '0);
    prod_q    <= coef_rd_q * mul_b;
    if (in_acc) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Round half up: add half an LSB, then drop the fraction bits (floor).
  assign rnd_sum = acc_q + RND_BIAS;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROUND) begin
      rnd_q <= rnd_sum[ACC_W-1:FRAC_W];
    end
  end

  // --------------------------------------------------------------------------
  // Output register with saturation
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      out_channel_o <= ch_q[0];
      priority if (rnd_q > SAT_HI) begin
        out_sample_o <= SAT_HI[DATA_W-1:0];
      end else if (rnd_q < SAT_LO) begin
        out_sample_o <= SAT_LO[DATA_W-1:0];
      end else begin
        out_sample_o <= rnd_q[DATA_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/fir2_checker.sv =====
// ----------------------------------------------------------------------------
// fir2_port_checks: port-level checks of the two-channel FIR filter
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module fir2_port_checks #(
  parameter int CHANNELS = 2
) (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_o,
  input wire logic                                action_i,
  input wire logic                                channel_i,
  input wire logic signed [fir2_pkg::DATA_W-1:0]  sample_i,
  input wire logic        [fir2_pkg::CIDX_W-1:0]  coef_index_i,
  input wire logic signed [fir2_pkg::DATA_W-1:0]  coef_value_i,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic signed [fir2_pkg::DATA_W-1:0]  out_sample_o,
  input wire logic                                out_channel_o
);
  import fir2_pkg::*;

  logic in_acc;
  logic filt_acc;

  assign in_acc   = in_valid_i && in_ready_o;
  assign filt_acc = in_acc && (action_i == ACT_FILTER) &&
                    ((channel_i == 1'b0) || (CHANNELS > 1));

  // A stalled result holds its value until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_sample_o) && $stable(out_channel_o))
    else $error("result changed while stalled");

  // A coefficient write never produces a result.
  a_coef_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (action_i == ACT_COEF) |=> !$rose(out_valid_o))
    else $error("coefficient write produced a result");

  // A filter request occupies the shared unit, so in_ready_o stays low after it is taken.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filt_acc |=> !in_ready_o ##1 !in_ready_o)
    else $error("request taken while the unit was busy");

  // A new result only appears at the end of the busy period.
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

endmodule

bind two_channel_fir_filter_top fir2_port_checks #(.CHANNELS(CHANNELS)) u_fir2_port_checks (.*);

`default_nettype wire

// ===== verif/fir2_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fir2_checker: predicts and compares the filtered samples of the FIR filter
// Watches both channels, runs its own copy of the coefficient store and delay
// lines, and counts every filtered sample that disagrees or is unexpected.
// ----------------------------------------------------------------------------

module fir2_checker
  import fir2_pkg::*;
#(
  parameter int TAPS = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     action_i,
  input  logic                     channel_i,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic        [CIDX_W-1:0] coef_index_i,
  input  logic signed [DATA_W-1:0] coef_value_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [DATA_W-1:0] out_sample_i,
  input  logic                     out_channel_i,
  output int                       mismatches_o,
  output int                       results_owed_o
);

  localparam int HIST_LEN = TAPS - 1;

  typedef struct packed {
    logic signed [DATA_W-1:0] smp;
    logic                     ch;
  } filtered_t;

  logic signed [DATA_W-1:0] coef_bank [TAPS];
  logic signed [DATA_W-1:0] tap_history [2][HIST_LEN];
  int                       hist_ptr [2];
  filtered_t                filtered_q [$];

  // Runs one sample through the taps of its channel and advances that line.
  function automatic filtered_t filter_sample(input logic ch,
                                              input logic signed [DATA_W-1:0] x);
    longint    acc;
    longint    rounded;
    int        pos;
    filtered_t res;
    pos = hist_ptr[ch];
    acc = longint'(coef_bank[0]) * longint'(x);
    for (int j = 0; j < HIST_LEN; j++) begin
      acc += longint'(coef_bank[j + 1]) * longint'(tap_history[ch][(j + pos) % HIST_LEN]);
    end
    // Round half up, then clamp to the Q1.15 range.
    rounded = (acc + 64'sd16384) >>> FRAC_W;
    if (rounded > 32767) rounded = 32767;
    if (rounded < -32768) rounded = -32768;
    tap_history[ch][pos] = x;
    hist_ptr[ch] = (pos + 1) % HIST_LEN;
    res.smp = rounded[DATA_W-1:0];
    res.ch = ch;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filtered_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) coef_bank[i] = '0;
      for (int c = 0; c < 2; c++) begin
        for (int i = 0; i < HIST_LEN; i++) tap_history[c][i] = '0;
        hist_ptr[c] = 0;
      end
      filtered_q.delete();
      mismatches_o = 0;
    end else begin
      // An output never belongs to the request taken at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected filtered sample %0d on channel %0d", out_sample_i,
                 out_channel_i);
          mismatches_o++;
        end else begin
          want = filtered_q.pop_front();
          if (out_sample_i !== want.smp) begin
            $error("out_sample: expected %0d, got %0d", want.smp, out_sample_i);
            mismatches_o++;
          end
          if (out_channel_i !== want.ch) begin
            $error("out_channel: expected %0d, got %0d", want.ch, out_channel_i);
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (action_i == ACT_COEF) begin
          if (int'(coef_index_i) < TAPS) coef_bank[coef_index_i] = coef_value_i;
        end else begin
          filtered_q.push_back(filter_sample(channel_i, sample_i));
        end
      end
    end
    results_owed_o = filtered_q.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the two-channel FIR filter
// Drives coefficient writes and filter requests with random gaps and output
// stalls; a separate checker predicts every filtered sample and compares it.
// ----------------------------------------------------------------------------

module tb;
  import fir2_pkg::*;

  localparam int TAPS         = 256;
  // Random requests after the directed opening.
  localparam int RANDOM_ITEMS = 680;
  // The final stretch of the run has no gaps and no output stalls.
  localparam int QUIET_ITEMS  = 100;
  // Wait longer than one filter request takes at the end, so that a stray
  // extra output would still be caught.
  localparam int TAIL_CYCLES  = TAPS + 40;
  // Cycles without any handshake before the run is declared hung. The
  // longest honest wait is the clearing pass after reset or one filter
  // request plus the longest stall on both sides.
  localparam int HANG_LIMIT   = 5000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  action_e                  req_action = ACT_FILTER;
  logic                     req_channel = 1'b0;
  logic signed [DATA_W-1:0] req_sample = '0;
  logic        [CIDX_W-1:0] req_coef_index = '0;
  logic signed [DATA_W-1:0] req_coef_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_sample;
  logic                     out_channel;

  int                       mismatches;
  int                       results_owed;
  logic                     quiet = 1'b0;
  int                       stall_left = 0;
  int                       idle_cycles = 0;

  always #10 clk_i = ~clk_i;

  two_channel_fir_filter_top #(
    .TAPS     (TAPS),
    .CHANNELS (2)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (req_action),
    .channel_i     (req_channel),
    .sample_i      (req_sample),
    .coef_index_i  (req_coef_index),
    .coef_value_i  (req_coef_value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_sample_o  (out_sample),
    .out_channel_o (out_channel)
  );

  fir2_checker #(
    .TAPS (TAPS)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .action_i       (req_action),
    .channel_i      (req_channel),
    .sample_i       (req_sample),
    .coef_index_i   (req_coef_index),
    .coef_value_i   (req_coef_value),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_sample_i   (out_sample),
    .out_channel_i  (out_channel),
    .mismatches_o   (mismatches),
    .results_owed_o (results_owed)
  );

  // The receiver stalls in random bursts, except in the final stretch where it
  // always accepts.
  always @(negedge clk_i) begin
    if (quiet) begin
      stall_left <= 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Hang detection: count cycles in which neither channel moves a request.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Presents one request at a falling edge, after an optional random gap,
  // and returns at the rising edge where it is accepted. Valid is only
  // lowered when a gap follows, so back-to-back requests keep it high.
  task automatic issue(input action_e act, input logic ch,
                       input logic signed [DATA_W-1:0] smp,
                       input logic [CIDX_W-1:0] idx,
                       input logic signed [DATA_W-1:0] val);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    req_action <= act;
    req_channel <= ch;
    req_sample <= smp;
    req_coef_index <= idx;
    req_coef_value <= val;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // The fields that a request does not use still carry random values so
  // that the block is seen to ignore them.
  task automatic write_coef(input logic [CIDX_W-1:0] idx,
                            input logic signed [DATA_W-1:0] val);
    issue(ACT_COEF, 1'($urandom()), DATA_W'($urandom()), idx, val);
  endtask

  task automatic push_sample(input logic ch, input logic signed [DATA_W-1:0] smp);
    issue(ACT_FILTER, ch, smp, CIDX_W'($urandom()), DATA_W'($urandom()));
  endtask

  // Holds the sender off until every predicted sample has come out.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);
  endtask

  initial begin
    logic signed [DATA_W-1:0] value;
    int                       kind;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening. With an empty coefficient store the output is zero.
    push_sample(1'b0, 16'sh7FFF);
    // Largest positive coefficient against both sample extremes.
    write_coef(8'd0, 16'sh7FFF);
    push_sample(1'b0, 16'sh7FFF);
    push_sample(1'b1, -16'sh8000);
    // Most negative times most negative overflows and clamps high.
    write_coef(8'd0, -16'sh8000);
    push_sample(1'b1, -16'sh8000);
    // The last slot weighs the previous sample of the channel; two large
    // positive samples in a row clamp low.
    write_coef(8'd255, -16'sh8000);
    push_sample(1'b0, 16'sh7FFF);
    push_sample(1'b0, 16'sh7FFF);
    // Alternating bit patterns in slot indexes and values.
    write_coef(8'd170, 16'sh5555);
    write_coef(8'd85, -16'sh5556);
    write_coef(8'd1, 16'sh0001);
    push_sample(1'b1, 16'sh0000);
    push_sample(1'b0, 16'sh0001);
    push_sample(1'b1, -16'sh0001);
    push_sample(1'b1, -16'sh8000);
    // Back to moderate weights so the random part is not stuck in clamping.
    write_coef(8'd0, 16'sh2000);
    write_coef(8'd255, -16'sh1000);
    write_coef(8'd170, 16'sh0000);
    write_coef(8'd85, 16'sh0000);
    push_sample(1'b0, 16'sh4000);
    push_sample(1'b1, -16'sh4000);
    wait_for_results();

    // Random part. Most coefficients are kept small so that sums over many
    // taps stay in range; a few use the full width. Samples mostly use the
    // full width, some are small to exercise fine rounding.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_for_results();
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      kind = $urandom_range(0, 9);
      value = DATA_W'($urandom());
      if ($urandom_range(0, 99) < 35) begin
        if (kind < 9) value = value >>> 4;
        write_coef(CIDX_W'($urandom_range(0, TAPS - 1)), value);
      end else begin
        if (kind < 2) value = value >>> 6;
        push_sample(1'($urandom()), value);
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && results_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fir2_pkg.sv
sv/two_channel_fir_filter_top.sv
sv/fir2_checker.sv
verif/fir2_checker.sv
verif/tb.sv
